// ===== rtl/core/sync_length_checksum_deframer_defines.svh =====
// Assertion macros for the sync/length/checksum deframer checker.
// No dependencies; pulled in with `include by files that assert.
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define SLCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define SLCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/slcd_pkg.sv =====
// Shared constants for the sync/length/checksum deframer.
// No dependencies; used by the core and its checker.
`timescale 1ns / 1ps

package slcd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 9;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned OUT_DATA_W = 80;

  // frame layout
  localparam logic [POS_W-1:0] POS_ADDR_FIRST = 9'd3;
  localparam logic [POS_W-1:0] POS_PORT_HI    = 9'd7;
  localparam logic [POS_W-1:0] POS_PORT_LO    = 9'd8;
  localparam logic [POS_W-1:0] POS_LENGTH     = 9'd9;
  localparam logic [POS_W-1:0] POS_TYPE       = 9'd10;
  localparam logic [POS_W-1:0] HEADER_BYTES   = 9'd11;

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'd126;

  // result kinds
  localparam logic [STATUS_W-1:0] ST_HEADER   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BODY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ACCEPT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SYNC_ERR = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SUM_ERR  = 3'd4;

endpackage

// ===== rtl/core/sync_length_checksum_deframer.sv =====
// Sync/length/checksum frame parser, one byte per word in, one result per word out.
// Depends on slcd_pkg.
`timescale 1ns / 1ps

//  channel | dir | tdata                          | tuser
//  in_     | in  | in_byte[7:0]                   | -
//  out_    | out | body/index/addr/port/type/len  | status[2:0]
//  cfg_    | in  | sync_char[7:0] (write only)    | -
//
// One word per cycle sustained while out_tready stays high; input register, then result register.
// The parser state is updated as a word moves from the input register to the result
// register, so back-to-back words see each other's effect with no bubble.
// rst_n (synchronous) clears both pipeline stages and the frame state, sync_char to 126.
// A stalled result holds both stages; in_tready falls only when both are full.

module sync_length_checksum_deframer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [slcd_pkg::BYTE_W-1:0]      in_tdata,   // [7:0] in_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] body_byte, [15:8] body_offset, [47:16] return_address,
  // [63:48] return_port_out, [71:64] message_type, [79:72] body_length
  output logic [slcd_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [slcd_pkg::STATUS_W-1:0]    out_tuser,  // [2:0] status
  input  logic                             cfg_we,
  input  logic [slcd_pkg::BYTE_W-1:0]      cfg_wdata   // [7:0] sync_char
);

  logic                            s1_valid_r;
  logic [slcd_pkg::BYTE_W-1:0]     s1_byte_r;
  logic                            s1_adv;

  logic [slcd_pkg::BYTE_W-1:0]     sync_r;
  logic [slcd_pkg::POS_W-1:0]      pos_r,    pos_nxt;
  logic [slcd_pkg::ADDR_W-1:0]     addr_r,   addr_nxt;
  logic [slcd_pkg::PORT_W-1:0]     port_r,   port_nxt;
  logic [slcd_pkg::BYTE_W-1:0]     len_r,    len_nxt;
  logic [slcd_pkg::BYTE_W-1:0]     type_r,   type_nxt;
  logic [slcd_pkg::BYTE_W-1:0]     sum_r,    sum_nxt;

  logic                            out_valid_r;
  logic [slcd_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [slcd_pkg::STATUS_W-1:0]   out_stat_r, out_stat_nxt;

  logic [slcd_pkg::POS_W-1:0]      sum_slot;
  logic                            take;
  logic                            clear;
  logic [slcd_pkg::BYTE_W-1:0]     bbyte, bidx;
  logic [slcd_pkg::ADDR_W-1:0]     raddr;
  logic [slcd_pkg::PORT_W-1:0]     rport;
  logic [slcd_pkg::BYTE_W-1:0]     rtype, rlen;

  // stage 1 moves on when the result register is free or being drained
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  always_comb begin
    sum_slot     = {1'b0, len_r} + slcd_pkg::HEADER_BYTES;
    addr_nxt     = addr_r;
    port_nxt     = port_r;
    len_nxt      = len_r;
    type_nxt     = type_r;
    take         = 1'b1;
    clear        = 1'b0;
    out_stat_nxt = slcd_pkg::ST_HEADER;
    bbyte        = '0;
    bidx         = '0;
    raddr        = '0;
    rport        = '0;
    rtype        = '0;
    rlen         = '0;

    if (pos_r < slcd_pkg::POS_ADDR_FIRST) begin
      if (s1_byte_r != sync_r) begin
        out_stat_nxt = slcd_pkg::ST_SYNC_ERR;
        take         = 1'b0;
        clear        = 1'b1;
      end
    end else if (pos_r < slcd_pkg::POS_PORT_HI) begin
      // big-endian: position 3 lands in the top byte
      case (pos_r[1:0])
        2'd3:    addr_nxt = addr_r | {s1_byte_r, 24'd0};
        2'd0:    addr_nxt = addr_r | {8'd0, s1_byte_r, 16'd0};
        2'd1:    addr_nxt = addr_r | {16'd0, s1_byte_r, 8'd0};
        default: addr_nxt = addr_r | {24'd0, s1_byte_r};
      endcase
    end else if (pos_r == slcd_pkg::POS_PORT_HI) begin
      port_nxt = port_r | {s1_byte_r, 8'd0};
    end else if (pos_r == slcd_pkg::POS_PORT_LO) begin
      port_nxt = port_r | {8'd0, s1_byte_r};
    end else if (pos_r == slcd_pkg::POS_LENGTH) begin
      len_nxt = s1_byte_r;
    end else if (pos_r == slcd_pkg::POS_TYPE) begin
      type_nxt = s1_byte_r;
    end else if (pos_r == sum_slot) begin
      take  = 1'b0;
      clear = 1'b1;
      if (s1_byte_r == sum_r) begin
        out_stat_nxt = slcd_pkg::ST_ACCEPT;
        raddr        = addr_r;
        rport        = port_r;
        rtype        = type_r;
        rlen         = len_r;
      end else begin
        out_stat_nxt = slcd_pkg::ST_SUM_ERR;
      end
    end else if (pos_r < sum_slot) begin
      out_stat_nxt = slcd_pkg::ST_BODY;
      bbyte        = s1_byte_r;
      bidx         = pos_r[slcd_pkg::BYTE_W-1:0] - slcd_pkg::HEADER_BYTES[slcd_pkg::BYTE_W-1:0];
    end else begin
      // beyond the checksum slot: unreachable, treated as a bad checksum
      take         = 1'b0;
      clear        = 1'b1;
      out_stat_nxt = slcd_pkg::ST_SUM_ERR;
    end

    sum_nxt = take ? sum_r + s1_byte_r : sum_r;
    pos_nxt = take ? pos_r + 9'd1 : pos_r;
    if (clear) begin
      pos_nxt  = '0;
      addr_nxt = '0;
      port_nxt = '0;
      len_nxt  = '0;
      type_nxt = '0;
      sum_nxt  = '0;
    end

    out_data_nxt = {rlen, rtype, rport, raddr, bidx, bbyte};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sync_r      <= slcd_pkg::SYNC_RESET;
      pos_r       <= '0;
      addr_r      <= '0;
      port_r      <= '0;
      len_r       <= '0;
      type_r      <= '0;
      sum_r       <= '0;
    end else begin
      if (cfg_we) begin
        sync_r <= cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        pos_r       <= pos_nxt;
        addr_r      <= addr_nxt;
        port_r      <= port_nxt;
        len_r       <= len_nxt;
        type_r      <= type_nxt;
        sum_r       <= sum_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
      out_stat_r <= out_stat_nxt;
    end
  end

endmodule

// ===== rtl/core/slcd_checker.sv =====
// Port-level checks for the deframer, bound into the deframer module.
// Depends on slcd_pkg and sync_length_checksum_deframer_defines.svh.
`timescale 1ns / 1ps
`include "sync_length_checksum_deframer_defines.svh"

module slcd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [slcd_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [slcd_pkg::STATUS_W-1:0]    out_tuser
);

  `SLCD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result word changed")

  `SLCD_ASSERT_NOW(a_ready_when_drained, !out_tvalid, in_tready,
    "input stalled while result register empty")

  `SLCD_ASSERT_NOW(a_status_range, out_tvalid,
    out_tuser == slcd_pkg::ST_HEADER || out_tuser == slcd_pkg::ST_BODY ||
    out_tuser == slcd_pkg::ST_ACCEPT || out_tuser == slcd_pkg::ST_SYNC_ERR ||
    out_tuser == slcd_pkg::ST_SUM_ERR, "status code out of range")

  `SLCD_ASSERT_NOW(a_body_fields_zero, out_tvalid && out_tuser != slcd_pkg::ST_BODY,
    out_tdata[15:0] == 16'd0, "body fields set outside a body word")

  `SLCD_ASSERT_NOW(a_header_fields_zero, out_tvalid && out_tuser != slcd_pkg::ST_ACCEPT,
    out_tdata[79:16] == 64'd0, "frame fields set outside an accept word")

endmodule

bind sync_length_checksum_deframer slcd_checker u_slcd_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking bench for sync_length_checksum_deframer: random and directed byte streams
// checked against a cycle-free parser model. Depends on slcd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [7:0]  blen;
    logic [7:0]  mtype;
    logic [15:0] port;
    logic [31:0] addr;
    logic [7:0]  idx;
    logic [7:0]  data;
  } out_word_t;

  typedef struct packed {
    logic [slcd_pkg::STATUS_W-1:0] status;
    out_word_t                     w;
  } parse_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [slcd_pkg::BYTE_W-1:0]     in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [slcd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [slcd_pkg::STATUS_W-1:0]   out_tuser;
  logic                            cfg_we = 1'b0;
  logic [slcd_pkg::BYTE_W-1:0]     cfg_wdata = '0;

  sync_length_checksum_deframer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // parser model state
  logic [slcd_pkg::BYTE_W-1:0] sync_mirror = slcd_pkg::SYNC_RESET;
  logic [slcd_pkg::POS_W-1:0]  frame_pos;
  logic [31:0]                 addr_shift;
  logic [15:0]                 port_shift;
  logic [7:0]                  len_seen;
  logic [7:0]                  type_seen;
  logic [7:0]                  running_sum;

  logic [7:0]    pending_bytes[$];
  logic [7:0]    frame_buf[$];
  parse_result_t predicted_words[$];

  int   send_idle_pct = 12;
  int   recv_idle_pct = 85;
  int   rx_stall_left = 0;
  logic in_fire_q = 1'b0;
  int   bytes_queued = 0;
  int   results_seen = 0;
  int   mismatches = 0;
  int   n_accept = 0;
  int   n_sum_err = 0;
  int   n_sync_err = 0;
  int   n_body = 0;
  logic [7:0] mid_sync;

  function automatic void restart_frame();
    frame_pos = '0;
    addr_shift = '0;
    port_shift = '0;
    len_seen = '0;
    type_seen = '0;
    running_sum = '0;
  endfunction

  function automatic parse_result_t parse_byte(input logic [7:0] b);
    parse_result_t              r;
    logic                       take;
    logic [slcd_pkg::POS_W-1:0] sum_slot;
    logic [slcd_pkg::POS_W-1:0] body_off;
    r = '0;
    r.status = slcd_pkg::ST_HEADER;
    take = 1'b1;
    sum_slot = {1'b0, len_seen} + slcd_pkg::HEADER_BYTES;
    if (frame_pos < slcd_pkg::POS_ADDR_FIRST) begin
      if (b != sync_mirror) begin
        r.status = slcd_pkg::ST_SYNC_ERR;
        take = 1'b0;
        restart_frame();
      end
    end else if (frame_pos < slcd_pkg::POS_PORT_HI) begin
      addr_shift = {addr_shift[23:0], b};   // big-endian, starts from zero
    end else if (frame_pos <= slcd_pkg::POS_PORT_LO) begin
      port_shift = {port_shift[7:0], b};
    end else if (frame_pos == slcd_pkg::POS_LENGTH) begin
      len_seen = b;
    end else if (frame_pos == slcd_pkg::POS_TYPE) begin
      type_seen = b;
    end else if (frame_pos == sum_slot) begin
      take = 1'b0;
      if (b == running_sum) begin
        r.status = slcd_pkg::ST_ACCEPT;
        r.w.addr = addr_shift;
        r.w.port = port_shift;
        r.w.mtype = type_seen;
        r.w.blen = len_seen;
      end else begin
        r.status = slcd_pkg::ST_SUM_ERR;
      end
      restart_frame();
    end else if (frame_pos < sum_slot) begin
      body_off = frame_pos - slcd_pkg::HEADER_BYTES;
      r.status = slcd_pkg::ST_BODY;
      r.w.data = b;
      r.w.idx = body_off[7:0];
    end else begin
      take = 1'b0;
      r.status = slcd_pkg::ST_SUM_ERR;
      restart_frame();
    end
    if (take) begin
      running_sum = running_sum + b;
      frame_pos = frame_pos + 1'b1;
    end
    return r;
  endfunction

  // whole frame with a correct checksum into frame_buf
  function automatic void build_frame(input logic [7:0] sync, input logic [31:0] addr,
                                      input logic [15:0] port, input logic [7:0] mtype,
                                      input int len);
    logic [7:0] sum;
    frame_buf = {};
    repeat (3) frame_buf.push_back(sync);
    frame_buf.push_back(addr[31:24]);
    frame_buf.push_back(addr[23:16]);
    frame_buf.push_back(addr[15:8]);
    frame_buf.push_back(addr[7:0]);
    frame_buf.push_back(port[15:8]);
    frame_buf.push_back(port[7:0]);
    frame_buf.push_back(8'(len));
    frame_buf.push_back(mtype);
    for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
    sum = '0;
    foreach (frame_buf[i]) sum = sum + frame_buf[i];
    frame_buf.push_back(sum);
  endfunction

  function automatic void queue_bytes(input int first, input int count);
    for (int i = first; i < first + count; i++) pending_bytes.push_back(frame_buf[i]);
    bytes_queued += count;
  endfunction

  function automatic void corrupt_sum();
    frame_buf[frame_buf.size()-1] = frame_buf[frame_buf.size()-1] ^ 8'($urandom_range(1, 255));
  endfunction

  // mostly good frames; the rest bad sums, bad sync, cut frames and line noise
  function automatic void add_random_frames(input logic [7:0] sync, input int target);
    int kind;
    int len;
    int k;
    int stop_at;
    stop_at = bytes_queued + target;
    while (bytes_queued < stop_at) begin
      kind = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
      build_frame(sync, $urandom, 16'($urandom), 8'($urandom), len);
      if (kind < 70) begin
        queue_bytes(0, frame_buf.size());
      end else if (kind < 80) begin
        corrupt_sum();
        queue_bytes(0, frame_buf.size());
      end else if (kind < 88) begin
        k = $urandom_range(2);
        frame_buf[k] = sync ^ 8'($urandom_range(1, 255));
        queue_bytes(0, k + 1);
      end else if (kind < 94) begin
        queue_bytes(0, $urandom_range(1, frame_buf.size() - 1));
      end else begin
        k = $urandom_range(1, 4);
        repeat (k) pending_bytes.push_back(8'($urandom));
        bytes_queued += k;
      end
    end
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch on result %0d: expected %h, got %h",
                 $realtime, fname, results_seen, want, got);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_tvalid || predicted_words.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sync(input logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sync_mirror = v;
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire_q) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_bytes.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      out_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // predict on input word, then check output word
  always @(posedge clk) begin
    parse_result_t want;
    out_word_t     got;
    in_fire_q <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) predicted_words.push_back(parse_byte(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      case (out_tuser)
        slcd_pkg::ST_BODY:     n_body++;
        slcd_pkg::ST_ACCEPT:   n_accept++;
        slcd_pkg::ST_SYNC_ERR: n_sync_err++;
        slcd_pkg::ST_SUM_ERR:  n_sum_err++;
        default:               ;
      endcase
      if (predicted_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d arrived with nothing expected (status %0d)",
                   $realtime, results_seen, out_tuser);
      end else begin
        want = predicted_words.pop_front();
        got = out_word_t'(out_tdata);
        check_field("status", 32'(want.status), 32'(out_tuser));
        check_field("body_byte", 32'(want.w.data), 32'(got.data));
        check_field("body_offset", 32'(want.w.idx), 32'(got.idx));
        check_field("return_address", want.w.addr, got.addr);
        check_field("return_port", 32'(want.w.port), 32'(got.port));
        check_field("message_type", 32'(want.w.mtype), 32'(got.mtype));
        check_field("body_length", 32'(want.w.blen), 32'(got.blen));
      end
    end
  end

  initial begin
    restart_frame();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset sync value
    build_frame(slcd_pkg::SYNC_RESET, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 0);
    queue_bytes(0, frame_buf.size());
    build_frame(slcd_pkg::SYNC_RESET, 32'h0, 16'h0, 8'h0, 1);
    corrupt_sum();
    queue_bytes(0, frame_buf.size());
    pending_bytes.push_back(~slcd_pkg::SYNC_RESET);     // bad first sync
    pending_bytes.push_back(slcd_pkg::SYNC_RESET);
    pending_bytes.push_back(slcd_pkg::SYNC_RESET);
    pending_bytes.push_back(8'h00);                     // bad third sync
    bytes_queued += 4;
    wait_idle();

    write_sync(8'h00);
    add_random_frames(8'h00, 100);
    wait_idle();

    send_idle_pct = 85;
    recv_idle_pct = 12;
    write_sync(8'hFF);
    build_frame(8'hFF, $urandom, 16'($urandom), 8'($urandom), 255);
    queue_bytes(0, frame_buf.size());
    add_random_frames(8'hFF, 60);
    wait_idle();

    // sync changes mid-frame; parser must carry on with the frame
    send_idle_pct = 0;
    recv_idle_pct = 0;
    build_frame(8'hFF, $urandom, 16'($urandom), 8'($urandom), 3);
    queue_bytes(0, 5);
    wait_idle();
    mid_sync = 8'($urandom_range(1, 254));
    write_sync(mid_sync);
    queue_bytes(5, frame_buf.size() - 5);
    add_random_frames(mid_sync, 40);
    @(posedge clk);
    rx_stall_left = 150;                                // back up the pipe
    add_random_frames(mid_sync, 70);
    wait_idle();

    write_sync(slcd_pkg::SYNC_RESET);
    add_random_frames(slcd_pkg::SYNC_RESET, 30);
    wait_idle();
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes, checked %0d results: %0d frames accepted, %0d checksum errors,",
             bytes_queued, results_seen, n_accept, n_sum_err);
    $display("  %0d sync errors, %0d body bytes; sync values 7e/00/ff/%h, stalls both sides",
             n_sync_err, n_body, mid_sync);
    if (mismatches == 0 && predicted_words.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/slcd_pkg.sv
rtl/core/sync_length_checksum_deframer.sv
rtl/core/slcd_checker.sv
dv/testbench.sv
